// ===== design/rvsp_pkg.sv =====
// shared constants, types and format tables of the raw video segment planner
package rvsp_pkg;

  // shared multiplier widths
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // payload accounting
  localparam int unsigned HEAD_BYTES    = 6;
  localparam int unsigned SEQ_EXT_BYTES = 2;
  localparam int unsigned MIN_PAYLOAD   = 16;

  // reciprocal multiply: floor(n / group_bytes) = (n * recip) >> RECIP_SHIFT, n < 2**16
  localparam int unsigned RECIP_SHIFT = 18;

  typedef enum logic [2:0] {
    FMT_UYVY422   = 3'd0,
    FMT_YUV422_10 = 3'd1,
    FMT_YUV420    = 3'd2,
    FMT_RGB24     = 3'd3,
    FMT_BGR24     = 3'd4
  } pix_fmt_e;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_PIXEL_FORMAT = 3'd2,
    REG_INTERLACED   = 3'd3,
    REG_MAX_PAYLOAD  = 3'd4
  } cfg_reg_e;

  function automatic logic fmt_known(logic [2:0] fmt);
    logic ok;
    case (fmt)
      FMT_UYVY422, FMT_YUV422_10, FMT_YUV420, FMT_RGB24, FMT_BGR24: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // bytes per pixel group
  function automatic logic [2:0] grp_bytes(logic [2:0] fmt);
    logic [2:0] gb;
    case (fmt)
      FMT_UYVY422:   gb = 3'd4;
      FMT_YUV422_10: gb = 3'd5;
      FMT_YUV420:    gb = 3'd6;
      FMT_RGB24:     gb = 3'd3;
      FMT_BGR24:     gb = 3'd3;
      default:       gb = 3'd3;
    endcase
    return gb;
  endfunction

  // log2 of pixels per pixel group
  function automatic logic [1:0] grp_px_lg(logic [2:0] fmt);
    logic [1:0] lg;
    case (fmt)
      FMT_UYVY422:   lg = 2'd1;
      FMT_YUV422_10: lg = 2'd1;
      FMT_YUV420:    lg = 2'd2;
      FMT_RGB24:     lg = 2'd0;
      FMT_BGR24:     lg = 2'd0;
      default:       lg = 2'd0;
    endcase
    return lg;
  endfunction

  // ceil(2**RECIP_SHIFT / group bytes)
  function automatic logic [MUL_B_W-1:0] grp_recip(logic [2:0] fmt);
    logic [MUL_B_W-1:0] r;
    case (fmt)
      FMT_UYVY422:   r = 17'd65536;
      FMT_YUV422_10: r = 17'd52429;
      FMT_YUV420:    r = 17'd43691;
      FMT_RGB24:     r = 17'd87382;
      FMT_BGR24:     r = 17'd87382;
      default:       r = 17'd87382;
    endcase
    return r;
  endfunction

endpackage

// ===== design/raw_video_rtp_segment_planner.sv =====
// top level of the raw video rtp segment planner
// Each accepted request plans the next RTP packet of a raw video frame and
// returns one result per segment header, the last one carrying the payload
// byte count and the end-of-frame marker. Work runs one request at a time:
// in_stall_o is high from acceptance until the last result has been
// transferred. A request that gives no result (unknown format or finished
// frame) goes from ST_START straight back to ST_IDLE. Otherwise each segment
// steps through ST_SEG, ST_LEN, ST_ROW, ST_SUM, ST_SRC and ST_OUT when the
// rest of the line fits, with ST_QUOT and ST_PLEN after ST_LEN when the line
// must be split, and a result waits in ST_OUT while out_stall_i is high; the
// steps are set by the single shared 32x17 multiplier with registered
// product, which forms three products in sequence per segment (group
// bytes, line times width, byte scaling) and two more for a split
// (reciprocal division, whole groups). A typical 1400-byte packet on a
// wide UYVY line is one split segment.
module raw_video_rtp_segment_planner
  import rvsp_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        new_frame_i,
  input  logic        field_parity_i,
  input  logic [31:0] frame_bytes_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] seg_length_o,
  output logic [14:0] line_number_o,
  output logic        field_bit_o,
  output logic [14:0] pixel_offset_o,
  output logic        continuation_o,
  output logic [31:0] source_offset_o,
  output logic        overrun_o,
  output logic        last_in_packet_o,
  output logic [15:0] packet_bytes_o,
  output logic        end_of_frame_o
);

  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SEG,
    ST_LEN,
    ST_QUOT,
    ST_PLEN,
    ST_ROW,
    ST_SUM,
    ST_SRC,
    ST_OUT
  } st_e;

  // configuration registers
  logic [14:0] fw_q;
  logic [14:0] fh_q;
  logic [2:0]  fmt_q;
  logic        il_q;
  logic [15:0] mp_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= 15'd1920;
      fh_q  <= 15'd1080;
      fmt_q <= FMT_UYVY422;
      il_q  <= 1'b0;
      mp_q  <= 16'd1400;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_FRAME_WIDTH:  fw_q  <= pwdata[14:0];
        REG_FRAME_HEIGHT: fh_q  <= pwdata[14:0];
        REG_PIXEL_FORMAT: fmt_q <= pwdata[2:0];
        REG_INTERLACED:   il_q  <= pwdata[0];
        REG_MAX_PAYLOAD:  mp_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_FRAME_WIDTH:  prdata = {17'd0, fw_q};
      REG_FRAME_HEIGHT: prdata = {17'd0, fh_q};
      REG_PIXEL_FORMAT: prdata = {29'd0, fmt_q};
      REG_INTERLACED:   prdata = {31'd0, il_q};
      REG_MAX_PAYLOAD:  prdata = {16'd0, mp_q};
      default:          prdata = 32'd0;
    endcase
  end

  // planner state
  st_e             state_q, state_d;
  logic [15:0]     cur_line_q, cur_line_d;
  logic [14:0]     line_off_q, line_off_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            field_q, field_d;
  logic [31:0]     avail_q, avail_d;
  logic [15:0]     left_q, left_d;
  logic [14:0]     pix_q, pix_d;
  logic [16:0]     len_q, len_d;
  logic            whole_q, whole_d;
  logic [14:0]     hdr_line_q, hdr_line_d;
  logic [14:0]     seg_off_q, seg_off_d;

  // result register
  logic        ov_q, ov_d;
  logic [15:0] o_len_q, o_len_d;
  logic [14:0] o_line_q, o_line_d;
  logic        o_field_q, o_field_d;
  logic [14:0] o_off_q, o_off_d;
  logic        o_cont_q, o_cont_d;
  logic [31:0] o_src_q, o_src_d;
  logic        o_over_q, o_over_d;
  logic        o_last_q, o_last_d;
  logic [15:0] o_pbytes_q, o_pbytes_d;
  logic        o_eof_q, o_eof_d;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  rvsp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  logic [2:0]  gb;
  logic [1:0]  lg;
  logic [15:0] budget;
  logic [14:0] pix_rest;
  logic [16:0] len_full;
  logic [14:0] quot;
  logic [14:0] hdr_line;
  logic [15:0] row;
  logic [31:0] base;
  logic [34:0] src;
  logic        more;

  assign gb     = grp_bytes(fmt_q);
  assign lg     = grp_px_lg(fmt_q);
  assign budget = (mp_q < 16'(MIN_PAYLOAD)) ? 16'(MIN_PAYLOAD) : mp_q;

  always_comb begin
    pix_rest = (line_off_q < fw_q) ? (fw_q - line_off_q) : 15'd0;
    len_full = 17'(mul_p >> lg);
    quot     = 15'(mul_p >> RECIP_SHIFT);
    hdr_line = il_q ? cur_line_q[15:1] : cur_line_q[14:0];
    row      = il_q ? {cur_line_q[15:1], field_q} : {1'b0, cur_line_q[14:0]};
    base     = 32'(mul_p) + 32'(seg_off_q);
    src      = 35'(mul_p >> lg);
    more     = (left_q > (16'(HEAD_BYTES) + 16'(gb))) &&
               (cur_line_q < {1'b0, fh_q}) &&
               (CntW'(cnt_q + 1'b1) < CntW'(MAX_SEGMENTS));
  end

  always_comb begin
    state_d    = state_q;
    cur_line_d = cur_line_q;
    line_off_d = line_off_q;
    cnt_d      = cnt_q;
    field_d    = field_q;
    avail_d    = avail_q;
    left_d     = left_q;
    pix_d      = pix_q;
    len_d      = len_q;
    whole_d    = whole_q;
    hdr_line_d = hdr_line_q;
    seg_off_d  = seg_off_q;
    ov_d       = ov_q;
    o_len_d    = o_len_q;
    o_line_d   = o_line_q;
    o_field_d  = o_field_q;
    o_off_d    = o_off_q;
    o_cont_d   = o_cont_q;
    o_src_d    = o_src_q;
    o_over_d   = o_over_q;
    o_last_d   = o_last_q;
    o_pbytes_d = o_pbytes_q;
    o_eof_d    = o_eof_q;
    mul_a      = '0;
    mul_b      = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (new_frame_i) begin
            cur_line_d = 16'd0;
            line_off_d = 15'd0;
          end
          field_d = field_parity_i;
          avail_d = frame_bytes_i;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (!fmt_known(fmt_q) || (cur_line_q >= {1'b0, fh_q})) begin
          state_d = ST_IDLE;
        end else begin
          left_d  = budget - 16'(SEQ_EXT_BYTES);
          cnt_d   = '0;
          state_d = ST_SEG;
        end
      end
      ST_SEG: begin
        pix_d   = pix_rest;
        left_d  = left_q - 16'(HEAD_BYTES);
        mul_a   = MUL_A_W'(pix_rest);
        mul_b   = MUL_B_W'(gb);
        state_d = ST_LEN;
      end
      ST_LEN: begin
        if ({1'b0, left_q} >= len_full) begin
          whole_d = 1'b1;
          len_d   = len_full;
          state_d = ST_ROW;
        end else begin
          // whole groups that fit: left / group bytes by reciprocal
          whole_d = 1'b0;
          mul_a   = MUL_A_W'(left_q);
          mul_b   = grp_recip(fmt_q);
          state_d = ST_QUOT;
        end
      end
      ST_QUOT: begin
        pix_d   = 15'(quot << lg);
        mul_a   = MUL_A_W'(quot);
        mul_b   = MUL_B_W'(gb);
        state_d = ST_PLEN;
      end
      ST_PLEN: begin
        len_d   = 17'(mul_p);
        state_d = ST_ROW;
      end
      ST_ROW: begin
        hdr_line_d = hdr_line;
        seg_off_d  = line_off_q;
        left_d     = left_q - len_q[15:0];
        mul_a      = MUL_A_W'(row);
        mul_b      = MUL_B_W'(fw_q);
        if (whole_q) begin
          cur_line_d = cur_line_q + (il_q ? 16'd2 : 16'd1);
          line_off_d = 15'd0;
        end else begin
          line_off_d = line_off_q + pix_q;
        end
        state_d = ST_SUM;
      end
      ST_SUM: begin
        mul_a   = base;
        mul_b   = MUL_B_W'(gb);
        state_d = ST_SRC;
      end
      ST_SRC: begin
        o_len_d    = len_q[15:0];
        o_line_d   = hdr_line_q;
        o_field_d  = field_q;
        o_off_d    = seg_off_q;
        o_cont_d   = more;
        o_src_d    = src[31:0];
        o_over_d   = ({1'b0, src} + 36'(len_q)) > 36'(avail_q);
        o_last_d   = !more;
        o_pbytes_d = more ? 16'd0 : (budget - left_q);
        o_eof_d    = !more && (cur_line_q >= {1'b0, fh_q});
        ov_d       = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          ov_d = 1'b0;
          if (o_cont_q) begin
            cnt_d   = cnt_q + 1'b1;
            state_d = ST_SEG;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_line_q <= 16'd0;
      line_off_q <= 15'd0;
      cnt_q      <= '0;
      ov_q       <= 1'b0;
      field_q    <= 1'b0;
      avail_q    <= 32'd0;
      left_q     <= 16'd0;
      pix_q      <= 15'd0;
      len_q      <= 17'd0;
      whole_q    <= 1'b0;
      hdr_line_q <= 15'd0;
      seg_off_q  <= 15'd0;
      o_len_q    <= 16'd0;
      o_line_q   <= 15'd0;
      o_field_q  <= 1'b0;
      o_off_q    <= 15'd0;
      o_cont_q   <= 1'b0;
      o_src_q    <= 32'd0;
      o_over_q   <= 1'b0;
      o_last_q   <= 1'b0;
      o_pbytes_q <= 16'd0;
      o_eof_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_line_q <= cur_line_d;
      line_off_q <= line_off_d;
      cnt_q      <= cnt_d;
      ov_q       <= ov_d;
      field_q    <= field_d;
      avail_q    <= avail_d;
      left_q     <= left_d;
      pix_q      <= pix_d;
      len_q      <= len_d;
      whole_q    <= whole_d;
      hdr_line_q <= hdr_line_d;
      seg_off_q  <= seg_off_d;
      o_len_q    <= o_len_d;
      o_line_q   <= o_line_d;
      o_field_q  <= o_field_d;
      o_off_q    <= o_off_d;
      o_cont_q   <= o_cont_d;
      o_src_q    <= o_src_d;
      o_over_q   <= o_over_d;
      o_last_q   <= o_last_d;
      o_pbytes_q <= o_pbytes_d;
      o_eof_q    <= o_eof_d;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = ov_q;
  assign seg_length_o     = o_len_q;
  assign line_number_o    = o_line_q;
  assign field_bit_o      = o_field_q;
  assign pixel_offset_o   = o_off_q;
  assign continuation_o   = o_cont_q;
  assign source_offset_o  = o_src_q;
  assign overrun_o        = o_over_q;
  assign last_in_packet_o = o_last_q;
  assign packet_bytes_o   = o_pbytes_q;
  assign end_of_frame_o   = o_eof_q;

  // a result is only presented while a request is in progress
  a_out_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result presented while idle");

  a_cont_xor_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (continuation_o != last_in_packet_o))
    else $error("continuation and last marker disagree");

  a_tail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_in_packet_o) |-> (packet_bytes_o == 16'd0 && !end_of_frame_o))
    else $error("packet totals on a non-final segment");

  a_seg_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (cnt_q < CntW'(MAX_SEGMENTS)))
    else $error("segment count past cap");

  a_out_from_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_SRC))
    else $error("result raised outside the final planning step");

endmodule

// ===== design/rvsp_mul.sv =====
// shared multiplier with registered product
module rvsp_mul
  import rvsp_pkg::*;
(
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_d;
  logic [MUL_P_W-1:0] p_q;

  always_comb begin
    p_d = a_i * b_i;
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
